/* rtl/rtcm3fs_pkg.sv */
// Shared types, constants and the CRC-24Q byte update for the RTCM3 framer.
package rtcm3fs_pkg;

  localparam logic [7:0]  PREAMBLE      = 8'hD3;
  localparam logic [7:0]  RESERVED_MASK = 8'hFC;
  localparam logic [24:0] CRC_POLY      = 25'h1864CFB;
  localparam logic [23:0] CRC_START     = 24'h000000;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_BODY = 3'd3,
    PH_CRC0 = 3'd4,
    PH_CRC1 = 3'd5,
    PH_CRC2 = 3'd6
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [9:0] byte_index;
    logic [9:0] frame_length;
    logic       crc_ok;
    logic       last;
  } result_t;

  // Eight bit-serial CRC steps, unrolled into one byte update.
  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage

/* rtl/rtcm3_frame_sync_crc24.sv */
// Top level: input byte register, frame state machine and result register.
// An accepted byte passes the input byte register, then the combinational framer, then the result register.
// Throughput: one byte per cycle while the output is not stalled; the CRC-24Q byte update is one unrolled stage.
// Bytes without a result (hunt, header, first two CRC bytes) produce no output transaction.
// Reset (asynchronous, active low) empties both registers and restarts the hunt.
module rtcm3_frame_sync_crc24 import rtcm3fs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] payload_byte_o,
  output logic [9:0] byte_index_o,
  output logic [9:0] frame_length_o,
  output logic       crc_ok_o,
  output logic       last_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_ready;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    res_out;

  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  rtcm3fs_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rtcm3fs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign kind_o         = res_out.kind;
  assign payload_byte_o = res_out.payload_byte;
  assign byte_index_o   = res_out.byte_index;
  assign frame_length_o = res_out.frame_length;
  assign crc_ok_o       = res_out.crc_ok;
  assign last_o         = res_out.last;

endmodule

/* rtl/rtcm3fs_framer.sv */
// Frame state machine: preamble hunt, header decode, payload count and CRC check.
module rtcm3fs_framer import rtcm3fs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [9:0]  frame_len_q, frame_len_d;
  logic [9:0]  count_q, count_d;
  logic [23:0] crc_q, crc_d;
  logic [15:0] rcv_high_q, rcv_high_d;
  logic [9:0]  count_inc;
  logic [23:0] crc_upd;

  assign count_inc = count_q + 10'd1;
  assign crc_upd   = crc_byte(crc_q, byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_len_q <= '0;
      count_q     <= '0;
      crc_q       <= CRC_START;
      rcv_high_q  <= '0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
      rcv_high_q  <= rcv_high_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    count_d     = count_q;
    crc_d       = crc_q;
    rcv_high_d  = rcv_high_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_HDR1: begin
        if ((byte_i & RESERVED_MASK) != 8'h00) begin
          phase_d = PH_HUNT;
        end else begin
          frame_len_d = {byte_i[1:0], 8'h00};
          crc_d       = crc_upd;
          phase_d     = PH_HDR2;
        end
      end
      PH_HDR2: begin
        frame_len_d = {frame_len_q[9:8], byte_i};
        crc_d       = crc_upd;
        count_d     = '0;
        phase_d     = ({frame_len_q[9:8], byte_i} == 10'd0) ? PH_CRC0 : PH_BODY;
      end
      PH_BODY: begin
        crc_d              = crc_upd;
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
        res_o.byte_index   = count_q;
        count_d            = count_inc;
        if (count_inc == frame_len_q) begin
          phase_d = PH_CRC0;
        end
      end
      PH_CRC0: begin
        rcv_high_d = {byte_i, 8'h00};
        phase_d    = PH_CRC1;
      end
      PH_CRC1: begin
        rcv_high_d = {rcv_high_q[15:8], byte_i};
        phase_d    = PH_CRC2;
      end
      PH_CRC2: begin
        res_valid_o        = 1'b1;
        res_o.kind         = 1'b1;
        res_o.frame_length = frame_len_q;
        res_o.crc_ok       = ({rcv_high_q, byte_i} == crc_q);
        res_o.last         = 1'b1;
        phase_d            = PH_HUNT;
      end
      default: begin
        // Hunting; unused phase codes land here as well.
        phase_d = PH_HUNT;
        if (byte_i == PREAMBLE) begin
          crc_d       = crc_byte(CRC_START, byte_i);
          frame_len_d = '0;
          count_d     = '0;
          rcv_high_d  = '0;
          phase_d     = PH_HDR1;
        end
      end
    endcase
  end

  a_body_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (frame_len_q != 10'd0))
    else $error("payload phase entered with zero length");

  a_body_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (count_q < frame_len_q))
    else $error("payload count ran past frame length");

  a_end_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_q == PH_CRC2) |=> (phase_q == PH_HUNT))
    else $error("frame end did not resume the hunt");

endmodule

/* rtl/rtcm3fs_out_stage.sv */
// Result register that holds a finished result until downstream takes it.
module rtcm3fs_out_stage import rtcm3fs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    ready_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule
